// ===== rtl/bsc_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// Base64 stream codec package
// Shared types, character constants and alphabet lookup functions.
// ----------------------------------------------------------------------------
package bsc_pkg;

    localparam logic [7:0] CHAR_PAD    = 8'd61;   // '='
    localparam logic [7:0] CHAR_PLUS   = 8'd43;   // '+'
    localparam logic [7:0] CHAR_SLASH  = 8'd47;   // '/'
    localparam logic [7:0] INVALID_VAL = 8'hFF;

    localparam logic DIR_ENCODE = 1'b0;
    localparam logic DIR_DECODE = 1'b1;

    // One group of results handed from the group logic to the output stage.
    // Entry 0 of bytes goes out first.
    typedef struct packed {
        logic [3:0][7:0] bytes;
        logic [2:0]      num;
        logic            last;
        logic            bad;
    } t_group;

    // Configuration write as seen by the group logic.
    typedef struct packed {
        logic we;
        logic dir;
    } t_cfg_wr;

    // 6-bit value to character of the standard alphabet.
    function automatic logic [7:0] b64_char(input logic [5:0] idx);
        logic [7:0] w;
        logic [7:0] c;
        w = {2'b00, idx};
        if (idx < 6'd26) begin
            c = w + 8'd65;
        end else if (idx < 6'd52) begin
            c = w + 8'd71;
        end else if (idx < 6'd62) begin
            c = w - 8'd4;
        end else if (idx == 6'd62) begin
            c = CHAR_PLUS;
        end else begin
            c = CHAR_SLASH;
        end
        return c;
    endfunction

    // Character to 6-bit value, INVALID_VAL for anything outside the alphabet.
    function automatic logic [7:0] b64_value(input logic [7:0] c);
        logic [7:0] v;
        if (c >= 8'd65 && c <= 8'd90) begin
            v = c - 8'd65;
        end else if (c >= 8'd97 && c <= 8'd122) begin
            v = c - 8'd71;
        end else if (c >= 8'd48 && c <= 8'd57) begin
            v = c + 8'd4;
        end else if (c == CHAR_PLUS) begin
            v = 8'd62;
        end else if (c == CHAR_SLASH) begin
            v = 8'd63;
        end else begin
            v = INVALID_VAL;
        end
        return v;
    endfunction

endpackage
`default_nettype wire

// ===== rtl/bsc_stream_if.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// Base64 stream codec channels
// Valid/ready interfaces for the input, output and configuration channels.
// ----------------------------------------------------------------------------
interface bsc_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       stream_last;

    modport source (output valid, output data_byte, output stream_last, input ready);
    modport sink   (input valid, input data_byte, input stream_last, output ready);
endinterface

interface bsc_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_byte;
    logic       run_last;
    logic       stream_end;
    logic       bad_char;

    modport source (output valid, output out_byte, output run_last, output stream_end,
                    output bad_char, input ready);
    modport sink   (input valid, input out_byte, input run_last, input stream_end,
                    input bad_char, output ready);
endinterface

interface bsc_cfg_if;
    logic valid;
    logic ready;
    logic direction;

    modport source (output valid, output direction, input ready);
    modport sink   (input valid, input direction, output ready);
endinterface
`default_nettype wire

// ===== rtl/bsc_group.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// Base64 group logic
// Input register, direction register and group state; builds one result group.
// ----------------------------------------------------------------------------
module bsc_group (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    bsc_in_if.sink                i_in_ch,
    input  wire bsc_pkg::t_cfg_wr i_cfg,
    input  wire logic             i_load_rdy,
    output bsc_pkg::t_group       o_group,
    output logic                  o_load
);
    import bsc_pkg::*;

    logic        r_in_vld, n_in_vld;
    logic [7:0]  r_in_byte;
    logic        r_in_last;
    logic        r_dir, n_dir;
    logic [23:0] r_bits, n_bits;
    logic [1:0]  r_count, n_count;
    logic        r_bad, n_bad;
    logic [1:0]  r_pad, n_pad;

    logic        in_fire;
    logic        proc_fire;
    logic        has_res;

    logic [1:0]  e_cnt;
    logic [1:0]  e_len;
    logic [23:0] e_bits;
    logic [23:0] e_next;
    logic        e_emit;
    logic [7:0]  c0, c1, c2, c3;

    logic [7:0]  d_val;
    logic [1:0]  d_pad;
    logic        d_bad;
    logic [7:0]  o0, o1, o2;
    logic [2:0]  d_num;

    // Encode path: place the byte, then map the three bytes to four characters.
    always_comb begin
        e_cnt  = (r_count == 2'd3) ? 2'd0 : r_count;
        e_bits = (r_count == 2'd3) ? 24'd0 : r_bits;
        case (e_cnt)
            2'd0:    e_next = e_bits | {r_in_byte, 16'd0};
            2'd1:    e_next = e_bits | {8'd0, r_in_byte, 8'd0};
            default: e_next = e_bits | {16'd0, r_in_byte};
        endcase
        e_len  = e_cnt + 2'd1;
        e_emit = (e_len == 2'd3) || r_in_last;
        c0 = b64_char(e_next[23:18]);
        c1 = b64_char(e_next[17:12]);
        c2 = (e_len > 2'd1) ? b64_char(e_next[11:6]) : CHAR_PAD;
        c3 = (e_len > 2'd2) ? b64_char(e_next[5:0])  : CHAR_PAD;
    end

    // Decode path: an invalid character enters the shifts as 0xFF.
    always_comb begin
        d_val = b64_value(r_in_byte);
        d_pad = r_pad;
        d_bad = r_bad;
        if (d_val == INVALID_VAL) begin
            if (r_in_byte == CHAR_PAD && r_count == 2'd2) begin
                d_pad[0] = 1'b1;
            end else if (r_in_byte == CHAR_PAD && r_count == 2'd3) begin
                d_pad[1] = 1'b1;
            end else begin
                d_bad = 1'b1;
            end
        end
        o0 = r_bits[23:16];
        o1 = r_bits[15:8];
        o2 = r_bits[7:0];
        case (r_count)
            2'd0: begin
                o0 = {d_val[5:0], 2'b00};
            end
            2'd1: begin
                o0 = o0 | {4'd0, d_val[7:4]};
                o1 = {d_val[3:0], 4'd0};
            end
            2'd2: begin
                o1 = o1 | {2'd0, d_val[7:2]};
                o2 = {d_val[1:0], 6'd0};
            end
            default: begin
                o2 = o2 | d_val;
            end
        endcase
        if (d_pad[0]) begin
            d_num = 3'd1;
        end else if (d_pad[1]) begin
            d_num = 3'd2;
        end else begin
            d_num = 3'd3;
        end
    end

    always_comb begin
        has_res   = (r_dir == DIR_DECODE) ? (r_count == 2'd3) : e_emit;
        proc_fire = r_in_vld && (!has_res || i_load_rdy);
        o_load    = r_in_vld && has_res && i_load_rdy;
        i_in_ch.ready = !r_in_vld || proc_fire;
        in_fire   = i_in_ch.valid && i_in_ch.ready;

        if (r_dir == DIR_DECODE) begin
            o_group.bytes = {8'd0, o2, o1, o0};
            o_group.num   = d_num;
            o_group.bad   = d_bad;
        end else begin
            o_group.bytes = {c3, c2, c1, c0};
            o_group.num   = 3'd4;
            o_group.bad   = 1'b0;
        end
        o_group.last = r_in_last;
    end

    always_comb begin
        n_in_vld = in_fire ? 1'b1 : (proc_fire ? 1'b0 : r_in_vld);
        n_dir    = r_dir;
        n_bits   = r_bits;
        n_count  = r_count;
        n_bad    = r_bad;
        n_pad    = r_pad;
        if (i_cfg.we) begin
            n_dir   = i_cfg.dir;
            n_bits  = 24'd0;
            n_count = 2'd0;
            n_bad   = 1'b0;
            n_pad   = 2'd0;
        end else if (proc_fire) begin
            if (r_dir == DIR_DECODE) begin
                if (r_count == 2'd3 || r_in_last) begin
                    n_bits  = 24'd0;
                    n_count = 2'd0;
                    n_bad   = 1'b0;
                    n_pad   = 2'd0;
                end else begin
                    n_bits  = {o0, o1, o2};
                    n_count = r_count + 2'd1;
                    n_bad   = d_bad;
                    n_pad   = d_pad;
                end
            end else begin
                n_bad = 1'b0;
                n_pad = 2'd0;
                if (e_emit) begin
                    n_bits  = 24'd0;
                    n_count = 2'd0;
                end else begin
                    n_bits  = e_next;
                    n_count = e_len;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
            r_dir    <= DIR_ENCODE;
            r_bits   <= 24'd0;
            r_count  <= 2'd0;
            r_bad    <= 1'b0;
            r_pad    <= 2'd0;
        end else begin
            r_in_vld <= n_in_vld;
            r_dir    <= n_dir;
            r_bits   <= n_bits;
            r_count  <= n_count;
            r_bad    <= n_bad;
            r_pad    <= n_pad;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_in_byte <= i_in_ch.data_byte;
            r_in_last <= i_in_ch.stream_last;
        end
    end

endmodule
`default_nettype wire

// ===== rtl/bsc_drain.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// Base64 result drain
// Holds one result group and hands it out one transfer per cycle while the receiver is ready.
// ----------------------------------------------------------------------------
module bsc_drain (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire bsc_pkg::t_group i_group,
    input  wire logic            i_load,
    output logic                 o_load_rdy,
    bsc_out_if.source            o_out_ch
);
    import bsc_pkg::*;

    logic [3:0][7:0] r_bytes;
    logic [2:0]      r_left;
    logic            r_last;
    logic            r_bad;
    logic            out_fire;

    always_comb begin
        o_out_ch.valid      = (r_left != 3'd0);
        o_out_ch.out_byte   = r_bytes[0];
        o_out_ch.run_last   = (r_left == 3'd1);
        o_out_ch.stream_end = (r_left == 3'd1) && r_last;
        o_out_ch.bad_char   = r_bad;
        out_fire   = o_out_ch.valid && o_out_ch.ready;
        // A new group may enter as the final result of the current one leaves.
        o_load_rdy = (r_left == 3'd0) || ((r_left == 3'd1) && out_fire);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_left <= 3'd0;
        end else if (i_load) begin
            r_left <= i_group.num;
        end else if (out_fire) begin
            r_left <= r_left - 3'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_bytes <= i_group.bytes;
            r_last  <= i_group.last;
            r_bad   <= i_group.bad;
        end else if (out_fire) begin
            r_bytes <= {8'd0, r_bytes[3:1]};
        end
    end

endmodule
`default_nettype wire

// ===== rtl/base64_stream_codec_unit.sv =====
`default_nettype none
// An item is registered in the input register at its transfer edge, and its group
// enters the drain when that is ready; the drain then offers its first result.
// Throughput: one input transfer per cycle while the item yields no result;
// results leave one per cycle from a four-entry drain while the output is ready;
// decoding takes one input per cycle, encoding less: three inputs give four results.
// Reset: synchronous, active low; clears the group state and selects encoding.
// ----------------------------------------------------------------------------
// Base64 stream codec top level
// Byte-stream Base64 encoder/decoder with a configurable direction.
// ----------------------------------------------------------------------------
module base64_stream_codec_unit (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    bsc_in_if.sink    i_in_ch,
    bsc_out_if.source o_out_ch,
    bsc_cfg_if.sink   i_cfg_ch
);
    import bsc_pkg::*;

    t_cfg_wr cfg_wr;
    t_group  grp;
    logic    load;
    logic    load_rdy;

    assign i_cfg_ch.ready = 1'b1;

    always_comb begin
        cfg_wr.we  = i_cfg_ch.valid && i_cfg_ch.ready;
        cfg_wr.dir = i_cfg_ch.direction;
    end

    bsc_group u_group (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_ch    (i_in_ch),
        .i_cfg      (cfg_wr),
        .i_load_rdy (load_rdy),
        .o_group    (grp),
        .o_load     (load)
    );

    bsc_drain u_drain (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_group    (grp),
        .i_load     (load),
        .o_load_rdy (load_rdy),
        .o_out_ch   (o_out_ch)
    );

endmodule
`default_nettype wire

// ===== rtl/bsc_checker.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// Base64 stream codec checker
// Port-level assertions on the result channel, bound to the top level.
// ----------------------------------------------------------------------------
module bsc_checker (
    input wire logic       i_clk,
    input wire logic       i_rst_n,
    input wire logic       i_out_valid,
    input wire logic       i_out_ready,
    input wire logic [7:0] i_out_byte,
    input wire logic       i_run_last,
    input wire logic       i_stream_end
);

    // A result that is not taken stays offered.
    a_valid_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid)
        else $error("result withdrawn before transfer");

    a_byte_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> $stable(i_out_byte))
        else $error("result byte changed while stalled");

    // The end of a stream is always the last result of its item.
    a_end_is_run_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_stream_end |-> i_run_last)
        else $error("stream end without run last");

    // Nothing is offered in the cycle after a reset cycle.
    a_reset_quiet: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("result offered right after reset");

endmodule

bind base64_stream_codec_unit bsc_checker u_bsc_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_out_valid  (o_out_ch.valid),
    .i_out_ready  (o_out_ch.ready),
    .i_out_byte   (o_out_ch.out_byte),
    .i_run_last   (o_out_ch.run_last),
    .i_stream_end (o_out_ch.stream_end)
);
`default_nettype wire
